/* design/psq_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// psq_pkg - shared types and constants for the positional sequence store
// Depth, derived widths, operation and status codes, cell control struct.
// ============================================================================
package psq_pkg;

    // Number of cells in the chain (2..31)
    localparam int DEPTH   = 16;
    // Width that holds an element count 0..DEPTH
    localparam int CNT_W   = $clog2(DEPTH + 1);
    // Port field widths
    localparam int MODE_W  = 3;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    // Compare width covering both the position field and the count
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes
    localparam logic [MODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] OP_INSERT_AT  = 3'd2;
    localparam logic [MODE_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [MODE_W-1:0] OP_REMOVE_AT  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic ins;    // open a gap this cycle
        logic rem;    // close a gap this cycle
        logic hit;    // this cell sits at the target index
        logic above;  // this cell lies behind the target index
    } t_cell_ctl;

endpackage

/* design/psq_cell.sv */
`timescale 1ns / 1ps
// ============================================================================
// psq_cell - one storage cell of the sequence chain
// Holds one element; loads the new value, its front neighbor or its back
// neighbor depending on the shift command, and taps out its value on a hit.
// ============================================================================
module psq_cell (
    input  logic                              i_clk,
    input  psq_pkg::t_cell_ctl                i_ctl,
    input  logic signed [psq_pkg::DATA_W-1:0] i_value,
    input  logic signed [psq_pkg::DATA_W-1:0] i_front,
    input  logic signed [psq_pkg::DATA_W-1:0] i_back,
    output logic signed [psq_pkg::DATA_W-1:0] o_data,
    output logic signed [psq_pkg::DATA_W-1:0] o_tap
);

    logic signed [psq_pkg::DATA_W-1:0] r_data;
    logic signed [psq_pkg::DATA_W-1:0] n_data;

    // Shift select: insert pulls from the front, remove pulls from the back
    always_comb begin
        priority if (i_ctl.ins && i_ctl.hit) begin
            n_data = i_value;
        end else if (i_ctl.ins && i_ctl.above) begin
            n_data = i_front;
        end else if (i_ctl.rem && (i_ctl.hit || i_ctl.above)) begin
            n_data = i_back;
        end else begin
            n_data = r_data;
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = i_ctl.hit ? r_data : '0;

endmodule

/* design/positional_sequence_store.sv */
`timescale 1ns / 1ps
// ============================================================================
// positional_sequence_store - bounded ordered sequence with positional edits
// Push/pop at either end, insert/remove at an index, over a chain of cells.
// ============================================================================
// Result beat: registered, presented in the cycle after the input beat is accepted.
// Throughput: one beat per cycle while o_ready holds (the result register is
//   empty or i_ready is high); every cell shifts in the same cycle.
// Reset: clears the element count and the output valid; cell contents are
//   left as they are and are never read past the count.
module positional_sequence_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [psq_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [psq_pkg::DATA_W-1:0]  i_value,
    input  logic [psq_pkg::POS_W-1:0]          i_position,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [psq_pkg::STAT_W-1:0]         o_status,
    output logic signed [psq_pkg::DATA_W-1:0]  o_removed_value,
    output logic [psq_pkg::COUNT_W-1:0]        o_count
);

    localparam int N = psq_pkg::DEPTH;
    localparam int W = psq_pkg::CMP_W;

    logic [psq_pkg::CNT_W-1:0]          r_occ;
    logic [psq_pkg::CNT_W-1:0]          n_occ;
    logic                               r_valid;
    logic [psq_pkg::STAT_W-1:0]         r_status;
    logic signed [psq_pkg::DATA_W-1:0]  r_removed;
    logic [psq_pkg::COUNT_W-1:0]        r_count;

    logic                               w_accept;
    logic [W-1:0]                       w_occ;
    logic [W-1:0]                       w_pos;
    logic [W-1:0]                       w_idx;
    logic                               w_ins;
    logic                               w_rem;
    logic [psq_pkg::STAT_W-1:0]         w_status;
    logic [W-1:0]                       w_occ_next;
    logic signed [psq_pkg::DATA_W-1:0]  w_removed;

    psq_pkg::t_cell_ctl                 w_ctl  [N];
    logic signed [psq_pkg::DATA_W-1:0]  w_data [N];
    logic signed [psq_pkg::DATA_W-1:0]  w_tap  [N];

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_occ    = W'(r_occ);
    assign w_pos    = W'(i_position);

    // Decode: target index, status and which way the chain shifts
    always_comb begin
        w_idx    = '0;
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        w_status = psq_pkg::ST_OK;
        unique case (i_mode)
            psq_pkg::OP_PUSH_FRONT, psq_pkg::OP_PUSH_BACK: begin
                w_idx = (i_mode == psq_pkg::OP_PUSH_FRONT) ? '0 : w_occ;
                if (w_occ >= W'(N)) begin
                    w_status = psq_pkg::ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            psq_pkg::OP_INSERT_AT: begin
                w_idx = w_pos;
                priority if (w_pos > w_occ) begin
                    w_status = psq_pkg::ST_BADPOS;
                end else if (w_occ >= W'(N)) begin
                    w_status = psq_pkg::ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            psq_pkg::OP_POP_FRONT, psq_pkg::OP_POP_BACK: begin
                w_idx = (i_mode == psq_pkg::OP_POP_FRONT) ? '0 : (w_occ - W'(1));
                if (w_occ == '0) begin
                    w_status = psq_pkg::ST_EMPTY;
                end else begin
                    w_rem = 1'b1;
                end
            end
            psq_pkg::OP_REMOVE_AT: begin
                w_idx = w_pos;
                priority if (w_occ == '0) begin
                    w_status = psq_pkg::ST_EMPTY;
                end else if (w_pos >= w_occ) begin
                    w_status = psq_pkg::ST_BADPOS;
                end else begin
                    w_rem = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Cell chain: each cell sees its front and back neighbor
    for (genvar k = 0; k < N; k++) begin : g_cell
        assign w_ctl[k].ins   = w_accept && w_ins;
        assign w_ctl[k].rem   = w_accept && w_rem;
        assign w_ctl[k].hit   = (w_idx == W'(k));
        assign w_ctl[k].above = (W'(k) > w_idx);

        psq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[k]),
            .i_value (i_value),
            .i_front ((k == 0)     ? '0 : w_data[(k == 0) ? 0 : k - 1]),
            .i_back  ((k == N - 1) ? '0 : w_data[(k == N - 1) ? k : k + 1]),
            .o_data  (w_data[k]),
            .o_tap   (w_tap[k])
        );
    end

    // Removed value: OR of the cell taps, only the target cell drives
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < N; k++) begin
            w_removed = w_removed | w_tap[k];
        end
        if (!w_rem) begin
            w_removed = '0;
        end
    end

    // Count update
    always_comb begin
        priority if (w_accept && w_ins) begin
            w_occ_next = w_occ + W'(1);
        end else if (w_accept && w_rem) begin
            w_occ_next = w_occ - W'(1);
        end else begin
            w_occ_next = w_occ;
        end
        n_occ = w_occ_next[psq_pkg::CNT_W-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= w_status;
            r_removed <= w_removed;
            r_count   <= w_occ_next[psq_pkg::COUNT_W-1:0];
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_count         = r_count;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        W'(r_occ) <= W'(N))
        else $error("element count beyond depth");

    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_status != psq_pkg::ST_OK)) |=> (r_occ == $past(r_occ)))
        else $error("refused operation changed the count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ins) |=> (W'(r_occ) == W'($past(r_occ)) + W'(1)))
        else $error("insert did not grow the count");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_status == psq_pkg::ST_EMPTY)) |-> (r_occ == '0))
        else $error("empty status on a non-empty store");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_count == W'(r_occ)))
        else $error("result count differs from stored count");

endmodule
